>>> src/encoder_period_speed_meter_macros.svh
// assertion macros for the encoder period speed meter
`ifndef ENCODER_PERIOD_SPEED_METER_MACROS_SVH
`define ENCODER_PERIOD_SPEED_METER_MACROS_SVH

// consequent holds in the same cycle as the antecedent
`define EPSM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// consequent holds in the cycle after the antecedent
`define EPSM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/epsm_pkg.sv
// shared constants and types for the encoder period speed meter
`timescale 1ns / 1ps

package epsm_pkg;

    localparam int SPEED_W  = 15;
    localparam int CAP_W    = 16;
    localparam int SCALE_W  = 24;
    localparam int TICK_W   = 10;
    localparam int LIMIT_W  = 16;
    localparam int CNT_W    = 17;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 24;
    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 32;
    localparam int DIV_CNT_W = $clog2(SCALE_W + 1);

    localparam int WINDOW_DEFAULT = 10;

    localparam logic [SPEED_W-1:0] SPEED_MAX   = {SPEED_W{1'b1}};
    localparam logic [CNT_W-1:0]   COUNTER_MAX = {CNT_W{1'b1}};

    localparam logic [SCALE_W-1:0] SCALE_RESET = SCALE_W'(120000);
    localparam logic [TICK_W-1:0]  TICK_RESET  = TICK_W'(50);
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(1000);

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_SPEED_SCALE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TICK_MS     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STOP_LIMIT  = 2'd2;

    // item kinds on s_tuser
    localparam logic OP_CAPTURE = 1'b0;
    localparam logic OP_TICK    = 1'b1;

    typedef struct packed {
        logic               start;
        logic [SCALE_W-1:0] dividend;
        logic [CAP_W-1:0]   divisor;
    } div_req_t;

endpackage

>>> src/encoder_period_speed_meter.sv
// encoder speed meter: capture period to speed, moving average, stop detect
//
// s_ channel takes one item per transfer: s_tuser is the kind (capture or
// tick), s_tdata the 16-bit capture timestamp. m_ channel returns exactly one
// result per item: speed and raw speed in m_tdata, the stop flag in m_tuser.
// cfg_ channel writes speed_scale (0), tick_ms (1), stop_limit_ms (2); other
// indexes are dropped. Write configuration only while the block is idle.
// A capture runs the period through a bit-serial divider; once the last ring
// slot is nonzero the window sum goes through the same divider a second time.
// A capture passes the raw divide, push, average divide (when averaging) and
// emit states; a tick goes straight to emit. One item is in flight at a time:
// a new item is taken only when the block is back in idle.
// Reset (aresetn low, synchronous) restores the register defaults and
// clears timestamp, ring, index, stop counter and both speeds.
// A stalled receiver holds the result in the output register; the block
// keeps working the next item and waits only to hand over its result.
`timescale 1ns / 1ps
`include "encoder_period_speed_meter_macros.svh"

module encoder_period_speed_meter #(
    parameter int WINDOW = epsm_pkg::WINDOW_DEFAULT
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // input stream
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [epsm_pkg::S_TDATA_W-1:0]      s_tdata,   // [15:0] capture_value
    input  logic                                s_tuser,   // [0] op
    // result stream
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [epsm_pkg::M_TDATA_W-1:0]      m_tdata,   // [14:0] speed, [29:15] raw_speed
    output logic                                m_tuser,   // [0] stopped
    // configuration writes
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [epsm_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [epsm_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int IDX_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int SUM_W = epsm_pkg::SPEED_W + $clog2(WINDOW);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV_RAW,
        ST_PUSH,
        ST_DIV_AVG,
        ST_EMIT
    } state_t;

    state_t state_reg;

    logic [epsm_pkg::SCALE_W-1:0]  scale_reg;
    logic [epsm_pkg::TICK_W-1:0]   tick_reg;
    logic [epsm_pkg::LIMIT_W-1:0]  limit_reg;

    logic [epsm_pkg::CAP_W-1:0]    last_cap_reg;
    logic [epsm_pkg::SPEED_W-1:0]  ring_reg [WINDOW];
    logic [IDX_W-1:0]              ring_index_reg;
    logic [SUM_W-1:0]              sum_reg;
    logic [epsm_pkg::CNT_W-1:0]    stop_cnt_reg;
    logic [epsm_pkg::SPEED_W-1:0]  speed_reg;
    logic [epsm_pkg::SPEED_W-1:0]  raw_reg;
    logic                          stopped_reg;

    logic                          m_tvalid_reg;
    logic [epsm_pkg::M_TDATA_W-1:0] m_tdata_reg;
    logic                          m_tuser_reg;

    logic                          in_xfer;
    logic                          cfg_xfer;
    logic [epsm_pkg::CAP_W-1:0]    cap;
    logic [epsm_pkg::CAP_W-1:0]    period;
    logic [epsm_pkg::CNT_W:0]      cnt_sum;
    logic [epsm_pkg::CNT_W-1:0]    cnt_sat;
    logic                          stop_hit;
    logic [epsm_pkg::SPEED_W-1:0]  raw_sat;
    logic                          out_free;

    epsm_pkg::div_req_t            div_req;
    logic                          div_done;
    logic [epsm_pkg::SCALE_W-1:0]  div_q;

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign in_xfer   = s_tvalid && s_tready;
    assign cfg_xfer  = cfg_valid && cfg_ready;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign cap       = s_tdata[epsm_pkg::CAP_W-1:0];

    // wrap rule: new minus old when new is greater, else new + (0xffff - old)
    assign period = (cap > last_cap_reg) ? (cap - last_cap_reg) : (cap + ~last_cap_reg);

    assign cnt_sum  = {1'b0, stop_cnt_reg} + (epsm_pkg::CNT_W + 1)'(tick_reg);
    assign cnt_sat  = cnt_sum[epsm_pkg::CNT_W] ? epsm_pkg::COUNTER_MAX
                                               : cnt_sum[epsm_pkg::CNT_W-1:0];
    assign stop_hit = in_xfer && (s_tuser == epsm_pkg::OP_TICK)
                      && (cnt_sat >= epsm_pkg::CNT_W'(limit_reg));

    // zero period divides to all ones, which saturates as well
    assign raw_sat = (div_q > epsm_pkg::SCALE_W'(epsm_pkg::SPEED_MAX))
                     ? epsm_pkg::SPEED_MAX : div_q[epsm_pkg::SPEED_W-1:0];

    always_comb begin
        div_req.start    = 1'b0;
        div_req.dividend = scale_reg;
        div_req.divisor  = period;
        if (state_reg == ST_PUSH) begin
            div_req.dividend = epsm_pkg::SCALE_W'(sum_reg);
            div_req.divisor  = epsm_pkg::CAP_W'(WINDOW);
            div_req.start    = (ring_reg[WINDOW-1] != '0);
        end else if (state_reg == ST_IDLE) begin
            div_req.start    = in_xfer && (s_tuser == epsm_pkg::OP_CAPTURE);
        end
    end

    epsm_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .req      (div_req),
        .done     (div_done),
        .quotient (div_q)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scale_reg <= epsm_pkg::SCALE_RESET;
            tick_reg  <= epsm_pkg::TICK_RESET;
            limit_reg <= epsm_pkg::LIMIT_RESET;
        end else if (cfg_xfer) begin
            case (cfg_index)
                epsm_pkg::REG_SPEED_SCALE: scale_reg <= cfg_data[epsm_pkg::SCALE_W-1:0];
                epsm_pkg::REG_TICK_MS:     tick_reg  <= cfg_data[epsm_pkg::TICK_W-1:0];
                epsm_pkg::REG_STOP_LIMIT:  limit_reg <= cfg_data[epsm_pkg::LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            last_cap_reg   <= '0;
            ring_index_reg <= '0;
            sum_reg        <= '0;
            stop_cnt_reg   <= '0;
            speed_reg      <= '0;
            raw_reg        <= '0;
            stopped_reg    <= 1'b0;
            m_tvalid_reg   <= 1'b0;
            for (int i = 0; i < WINDOW; i++) begin
                ring_reg[i] <= '0;
            end
        end else begin
            if ((state_reg == ST_EMIT) && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (in_xfer) begin
                        if (s_tuser == epsm_pkg::OP_CAPTURE) begin
                            last_cap_reg <= cap;
                            stop_cnt_reg <= '0;
                            stopped_reg  <= 1'b0;
                            state_reg    <= ST_DIV_RAW;
                        end else begin
                            stopped_reg <= stop_hit;
                            if (stop_hit) begin
                                stop_cnt_reg   <= '0;
                                ring_index_reg <= '0;
                                sum_reg        <= '0;
                                speed_reg      <= '0;
                                raw_reg        <= '0;
                                for (int i = 0; i < WINDOW; i++) begin
                                    ring_reg[i] <= '0;
                                end
                            end else begin
                                stop_cnt_reg <= cnt_sat;
                            end
                            state_reg <= ST_EMIT;
                        end
                    end
                end
                ST_DIV_RAW: begin
                    if (div_done) begin
                        raw_reg                  <= raw_sat;
                        ring_reg[ring_index_reg] <= raw_sat;
                        // running window sum: drop the overwritten entry, add the new one
                        sum_reg <= sum_reg - SUM_W'(ring_reg[ring_index_reg]) + SUM_W'(raw_sat);
                        if (ring_index_reg == IDX_W'(WINDOW - 1)) begin
                            ring_index_reg <= '0;
                        end else begin
                            ring_index_reg <= ring_index_reg + 1'b1;
                        end
                        state_reg <= ST_PUSH;
                    end
                end
                ST_PUSH: begin
                    // until the last slot fills, report the first entry
                    if (ring_reg[WINDOW-1] == '0) begin
                        speed_reg <= ring_reg[0];
                        state_reg <= ST_EMIT;
                    end else begin
                        state_reg <= ST_DIV_AVG;
                    end
                end
                ST_DIV_AVG: begin
                    if (div_done) begin
                        speed_reg <= div_q[epsm_pkg::SPEED_W-1:0];
                        state_reg <= ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    if (out_free) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if ((state_reg == ST_EMIT) && out_free) begin
            m_tdata_reg <= epsm_pkg::M_TDATA_W'({raw_reg, speed_reg});
            m_tuser_reg <= stopped_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    `EPSM_ASSERT_NOW(a_index_in_range, 1'b1,
        ring_index_reg <= IDX_W'(WINDOW - 1), "ring index beyond window")

    `EPSM_ASSERT_NOW(a_div_done_state, div_done,
        (state_reg == ST_DIV_RAW) || (state_reg == ST_DIV_AVG),
        "divider finished outside a divide state")

    `EPSM_ASSERT_NEXT(a_stop_clears, stop_hit,
        (sum_reg == '0) && (ring_index_reg == '0) && (raw_reg == '0) && (speed_reg == '0),
        "stop did not clear the filter")

    `EPSM_ASSERT_NOW(a_emit_once, (state_reg == ST_EMIT) && out_free,
        !(m_tvalid_reg && !m_tready), "result overwrote a pending transfer")

endmodule

>>> src/epsm_div.sv
// bit-serial restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps

module epsm_div (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  epsm_pkg::div_req_t              req,
    output logic                            done,
    output logic [epsm_pkg::SCALE_W-1:0]    quotient
);

    logic [epsm_pkg::DIV_CNT_W-1:0] cnt_reg;
    logic [epsm_pkg::SCALE_W-1:0]   dvd_reg;
    logic [epsm_pkg::CAP_W-1:0]     rem_reg;
    logic [epsm_pkg::CAP_W-1:0]     dsr_reg;
    logic                           done_reg;

    logic [epsm_pkg::CAP_W:0]       trial;
    logic [epsm_pkg::CAP_W:0]       diff;
    logic                           ge;

    // shift the next dividend bit into the partial remainder and try a subtract
    assign trial = {rem_reg, dvd_reg[epsm_pkg::SCALE_W-1]};
    assign diff  = trial - {1'b0, dsr_reg};
    assign ge    = (trial >= {1'b0, dsr_reg});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= !req.start && (cnt_reg == epsm_pkg::DIV_CNT_W'(1));
            if (req.start) begin
                cnt_reg <= epsm_pkg::DIV_CNT_W'(epsm_pkg::SCALE_W);
            end else if (cnt_reg != '0) begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            dvd_reg <= req.dividend;
            dsr_reg <= req.divisor;
            rem_reg <= '0;
        end else if (cnt_reg != '0) begin
            // a failed trial leaves a value below the divisor, so it fits
            rem_reg <= ge ? diff[epsm_pkg::CAP_W-1:0] : trial[epsm_pkg::CAP_W-1:0];
            dvd_reg <= {dvd_reg[epsm_pkg::SCALE_W-2:0], ge};
        end
    end

    assign done     = done_reg;
    assign quotient = dvd_reg;

endmodule

>>> test/tb_top.sv
// testbench for the encoder period speed meter: directed and random traffic with a checker
`timescale 1ns / 1ps

module tb_top;
    import epsm_pkg::*;

    localparam int RING_LEN      = WINDOW_DEFAULT;
    localparam int GAP_MAX       = 14;
    localparam int SETTLE_CYCLES = 80;
    localparam int CYCLE_LIMIT   = 800000;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    typedef struct packed {
        logic [SPEED_W-1:0] speed;
        logic [SPEED_W-1:0] raw_speed;
        logic               stopped;
    } reading_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;    // [15:0] capture_value
    logic                  s_tuser   = 1'b0;  // [0] op
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;           // [14:0] speed, [29:15] raw_speed
    logic                  m_tuser;           // [0] stopped
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    encoder_period_speed_meter dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // predicted meter state
    logic [SCALE_W-1:0] pm_scale  = SCALE_RESET;
    logic [TICK_W-1:0]  pm_tick   = TICK_RESET;
    logic [LIMIT_W-1:0] pm_limit  = LIMIT_RESET;
    logic [CAP_W-1:0]   pm_last_cap = '0;
    logic [SPEED_W-1:0] pm_ring [RING_LEN];
    int unsigned        pm_slot   = 0;
    logic [CNT_W-1:0]   pm_idle_ms = '0;
    logic [SPEED_W-1:0] pm_speed  = '0;
    logic [SPEED_W-1:0] pm_raw    = '0;

    reading_t pending_readings[$];

    bit no_gaps = 1'b0;
    int fail_count = 0;
    int cycle_count = 0;
    int n_items = 0, n_captures = 0, n_ticks = 0, n_stops = 0, n_averaged = 0;
    int n_results = 0, n_cfg_writes = 0;
    int rx_wait = 0;

    initial begin
        for (int i = 0; i < RING_LEN; i++) pm_ring[i] = '0;
    end

    function automatic int draw_gap();
        return no_gaps ? 0 : int'($urandom_range(0, GAP_MAX));
    endfunction

    function automatic reading_t predict_reading(logic op, logic [CAP_W-1:0] cap);
        int unsigned period;
        int unsigned quot;
        int unsigned total;
        int unsigned idle;
        reading_t r;
        r.stopped = 1'b0;
        if (op == OP_CAPTURE) begin
            // wrap rule: an equal timestamp counts as a full timer period
            if (cap > pm_last_cap) period = 32'(cap) - 32'(pm_last_cap);
            else period = 32'(cap) + 32'hFFFF - 32'(pm_last_cap);
            pm_last_cap = cap;
            if (period == 0) begin
                pm_raw = SPEED_MAX;
            end else begin
                quot = 32'(pm_scale) / period;
                pm_raw = (quot > 32'(SPEED_MAX)) ? SPEED_MAX : SPEED_W'(quot);
            end
            pm_ring[pm_slot] = pm_raw;
            pm_slot = (pm_slot + 1) % RING_LEN;
            total = 0;
            for (int i = 0; i < RING_LEN; i++) total += 32'(pm_ring[i]);
            if (pm_ring[RING_LEN-1] == '0) begin
                pm_speed = pm_ring[0];
            end else begin
                pm_speed = SPEED_W'(total / RING_LEN);
                n_averaged++;
            end
            pm_idle_ms = '0;
            n_captures++;
        end else begin
            idle = 32'(pm_idle_ms) + 32'(pm_tick);
            if (idle > 32'(COUNTER_MAX)) idle = 32'(COUNTER_MAX);
            if (idle >= 32'(pm_limit)) begin
                pm_raw = '0;
                pm_speed = '0;
                pm_slot = 0;
                for (int i = 0; i < RING_LEN; i++) pm_ring[i] = '0;
                idle = 0;
                r.stopped = 1'b1;
                n_stops++;
            end
            pm_idle_ms = CNT_W'(idle);
            n_ticks++;
        end
        r.speed = pm_speed;
        r.raw_speed = pm_raw;
        return r;
    endfunction

    // leaves s_tvalid high so a following item can go back to back
    task automatic send_item(logic op, logic [CAP_W-1:0] cap);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= cap;
        do @(posedge aclk); while (!s_tready);
        pending_readings.push_back(predict_reading(op, cap));
        n_items++;
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending_readings.size() != 0);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_SPEED_SCALE: pm_scale = data;
            REG_TICK_MS:     pm_tick  = data[TICK_W-1:0];
            REG_STOP_LIMIT:  pm_limit = data[LIMIT_W-1:0];
            default:         ;
        endcase
        n_cfg_writes++;
        @(posedge aclk);
    endtask

    // result checker with random receiver stalls
    always @(posedge aclk) begin : result_check
        reading_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
            rx_wait = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                n_results++;
                if (pending_readings.size() == 0) begin
                    $error("result with nothing pending: speed %0d raw_speed %0d stopped %0b",
                           m_tdata[14:0], m_tdata[29:15], m_tuser);
                    fail_count++;
                end else begin
                    want = pending_readings.pop_front();
                    if (m_tdata[14:0] !== want.speed) begin
                        $error("speed mismatch: expected %0d, got %0d", want.speed, m_tdata[14:0]);
                        fail_count++;
                    end
                    if (m_tdata[29:15] !== want.raw_speed) begin
                        $error("raw_speed mismatch: expected %0d, got %0d",
                               want.raw_speed, m_tdata[29:15]);
                        fail_count++;
                    end
                    if (m_tuser !== want.stopped) begin
                        $error("stopped mismatch: expected %0b, got %0b", want.stopped, m_tuser);
                        fail_count++;
                    end
                end
                rx_wait = draw_gap();
            end else if (rx_wait > 0) begin
                rx_wait--;
            end
            m_tready <= (rx_wait == 0);
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still pending",
                     cycle_count, pending_readings.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // zero period, saturation, equal timestamps and wrap with reset registers
    task automatic test_period_extremes();
        send_item(OP_CAPTURE, 16'h0001);
        send_item(OP_CAPTURE, 16'hFFFF);
        send_item(OP_CAPTURE, 16'h0000);
        send_item(OP_CAPTURE, 16'h0000);
        send_item(OP_TICK, 16'hA5A5);
    endtask

    // fill the ring so the mean takes over, then wrap the write index
    task automatic test_moving_average();
        logic [CAP_W-1:0] stamp;
        stamp = 16'd0;
        repeat (7) begin
            stamp = stamp + 16'd100 + CAP_W'($urandom_range(0, 30));
            send_item(OP_CAPTURE, stamp);
        end
    endtask

    task automatic test_stop_detect();
        drain_results();
        write_reg(REG_TICK_MS, 24'd600);
        write_reg(REG_STOP_LIMIT, 24'd1000);
        send_item(OP_TICK, 16'h0000);
        send_item(OP_TICK, 16'hFFFF);
        send_item(OP_CAPTURE, 16'h8000);
        drain_results();
        // zero limit stops on any tick, even with a zero step
        write_reg(REG_STOP_LIMIT, 24'd0);
        write_reg(REG_TICK_MS, 24'd0);
        send_item(OP_TICK, 16'h1234);
        drain_results();
        write_reg(REG_STOP_LIMIT, 24'd60000);
        send_item(OP_CAPTURE, 16'h8100);
        send_item(OP_TICK, 16'h0000);
    endtask

    task automatic test_register_extremes();
        drain_results();
        write_reg(REG_SPEED_SCALE, 24'd0);
        send_item(OP_CAPTURE, 16'h8200);
        drain_results();
        write_reg(REG_SPEED_SCALE, 24'hFFFFFF);
        send_item(OP_CAPTURE, 16'h8300);
        drain_results();
        write_reg(REG_SPEED_SCALE, 24'd1);
        write_reg(REG_UNUSED, 24'hFFFFFF);
        send_item(OP_CAPTURE, 16'h8301);
        send_item(OP_CAPTURE, 16'h8300);
    endtask

    task automatic traffic_phase(logic [CFG_DATA_W-1:0] scale, logic [TICK_W-1:0] tick,
                                 logic [LIMIT_W-1:0] limit, int n_phase, bit quiet);
        logic [CFG_DATA_W-1:0] word;
        logic [CAP_W-1:0] stamp;
        int unsigned pick;
        int burst;
        int sent;
        drain_results();
        write_reg(REG_SPEED_SCALE, scale);
        // upper bits of the narrower registers are don't-care
        word = CFG_DATA_W'($urandom());
        if ($urandom_range(0, 1) == 0) word = '0;
        word[TICK_W-1:0] = tick;
        write_reg(REG_TICK_MS, word);
        word = CFG_DATA_W'($urandom());
        if ($urandom_range(0, 1) == 0) word = '0;
        word[LIMIT_W-1:0] = limit;
        write_reg(REG_STOP_LIMIT, word);
        if ($urandom_range(0, 2) == 0) write_reg(REG_UNUSED, CFG_DATA_W'($urandom()));
        no_gaps = quiet;
        sent = 0;
        while (sent < n_phase) begin
            pick = $urandom_range(0, 99);
            if (pick < 10) begin
                // run of ticks long enough to reach the stop limit now and then
                burst = $urandom_range(1, 30);
                repeat (burst) send_item(OP_TICK, CAP_W'($urandom()));
                sent += burst;
            end else if (pick < 14) begin
                send_item(OP_TICK, CAP_W'($urandom()));
                sent++;
            end else if (pick < 22) begin
                send_item(OP_CAPTURE, CAP_W'($urandom()));
                sent++;
            end else if (pick < 23) begin
                drain_results();
            end else begin
                if ($urandom_range(0, 3) == 0) stamp = pm_last_cap + CAP_W'($urandom_range(0, 40));
                else stamp = pm_last_cap + CAP_W'($urandom_range(40, 3000));
                send_item(OP_CAPTURE, stamp);
                sent++;
            end
        end
        no_gaps = 1'b0;
    endtask

    task automatic test_random_traffic();
        traffic_phase(24'd120000, 10'd50, 16'd1000, 190, 1'b0);
        traffic_phase(24'hFFFFFF, 10'd1023, 16'd65535, 190, 1'b1);
        traffic_phase(24'd1, 10'd1, 16'd1, 190, 1'b0);
        traffic_phase(CFG_DATA_W'($urandom()), TICK_W'($urandom_range(1, 1000)),
                      LIMIT_W'($urandom_range(1, 60000)), 190, 1'b0);
        traffic_phase(24'd0, 10'd0, 16'd60000, 190, 1'b0);
        traffic_phase(CFG_DATA_W'($urandom_range(1, 2000000)), 10'd1000, 16'd0, 190, 1'b1);
        traffic_phase(CFG_DATA_W'($urandom_range(60000, 600000)), TICK_W'($urandom_range(1, 200)),
                      LIMIT_W'($urandom_range(100, 3000)), 190, 1'b0);
        traffic_phase(CFG_DATA_W'($urandom()), TICK_W'($urandom()), LIMIT_W'($urandom()),
                      190, 1'b0);
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        test_period_extremes();
        test_moving_average();
        test_stop_detect();
        test_register_extremes();
        test_random_traffic();
        drain_results();
        // catch any stray result after the last expected one
        repeat (SETTLE_CYCLES) @(posedge aclk);
        $display("sent %0d items: %0d captures, %0d ticks, %0d stop clears, %0d averaged speeds",
                 n_items, n_captures, n_ticks, n_stops, n_averaged);
        $display("checked %0d results across %0d register writes, %0d mismatches",
                 n_results, n_cfg_writes, fail_count);
        if (fail_count == 0 && pending_readings.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
